@@ design/cmm_pkg.sv @@
package cmm_pkg;

	localparam int NUM_CATEGORIES       = 32;
	localparam int ENTRIES_PER_CATEGORY = 256;

	localparam int MASK_W   = 32;
	localparam int VISIT_W  = 16;
	localparam int CODE_W   = 17;
	localparam int MODE_W   = 2;
	localparam int CATF_W   = 5;
	localparam int SLOT_W   = 8;
	localparam int CNTF_W   = 9;

	localparam int SEARCHED  = (NUM_CATEGORIES < MASK_W) ? NUM_CATEGORIES : MASK_W;
	localparam int CAT_W     = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
	localparam int IDX_W     = (ENTRIES_PER_CATEGORY > 1) ? $clog2(ENTRIES_PER_CATEGORY) : 1;
	localparam int CNT_W     = $clog2(ENTRIES_PER_CATEGORY + 1);
	localparam int TBL_DEPTH = NUM_CATEGORIES * ENTRIES_PER_CATEGORY;
	localparam int ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE    = 2'd0,
		MODE_COUNT    = 2'd1,
		MODE_CLASSIFY = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_EMIT
	} ctl_state_t;

	typedef enum logic [1:0] {
		SR_IDLE,
		SR_CAT,
		SR_PROBE
	} srch_state_t;

	typedef struct packed {
		logic              start;
		logic [CODE_W-1:0] code;
	} srch_req_t;

	typedef struct packed {
		logic              done;
		logic [MASK_W-1:0] mask;
	} srch_rsp_t;

	function automatic logic [ADDR_W-1:0] tbl_addr(input logic [CAT_W-1:0] cat,
		input logic [IDX_W-1:0] idx);
		return ADDR_W'(cat) * ADDR_W'(ENTRIES_PER_CATEGORY) + ADDR_W'(idx);
	endfunction

endpackage

@@ design/cmm_ram.sv @@
module cmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/cmm_search.sv @@
module cmm_search (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cmm_pkg::srch_req_t               req,
	output cmm_pkg::srch_rsp_t               rsp,
	output logic [cmm_pkg::CAT_W-1:0]        cat,
	input  logic [cmm_pkg::CNT_W-1:0]        cat_count,
	output logic [cmm_pkg::ADDR_W-1:0]       rd_addr,
	input  logic [cmm_pkg::CODE_W-1:0]       rd_data
);

	cmm_pkg::srch_state_t state_q, state_n;
	logic [cmm_pkg::CAT_W-1:0]  cat_q, cat_n;
	logic [cmm_pkg::CNT_W-1:0]  lo_q, lo_n, hi_q, hi_n;
	logic [cmm_pkg::IDX_W-1:0]  mid_q, mid_n;
	logic                       eq_q, eq_n;
	logic [cmm_pkg::MASK_W-1:0] mask_q, mask_n;
	logic                       done_q, done_n;
	logic                       cat_end, hit, cat_last;

	assign cat_last = (cat_q == cmm_pkg::CAT_W'(cmm_pkg::SEARCHED - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmm_pkg::SR_IDLE;
			cat_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			mid_q   <= '0;
			eq_q    <= 1'b0;
			mask_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			cat_q   <= cat_n;
			lo_q    <= lo_n;
			hi_q    <= hi_n;
			mid_q   <= mid_n;
			eq_q    <= eq_n;
			mask_q  <= mask_n;
			done_q  <= done_n;
		end
	end

	always_comb begin
		state_n = state_q;
		cat_n   = cat_q;
		lo_n    = lo_q;
		hi_n    = hi_q;
		mid_n   = mid_q;
		eq_n    = eq_q;
		mask_n  = mask_q;
		done_n  = 1'b0;
		cat_end = 1'b0;
		hit     = 1'b0;
		unique case (state_q)
			cmm_pkg::SR_IDLE: begin
				if (req.start) begin
					cat_n   = '0;
					mask_n  = '0;
					state_n = cmm_pkg::SR_CAT;
				end
			end
			cmm_pkg::SR_CAT: begin
				lo_n = '0;
				hi_n = cat_count;
				eq_n = 1'b0;
				if (cat_count == '0) begin
					cat_end = 1'b1;
				end else begin
					mid_n   = cmm_pkg::IDX_W'(cat_count >> 1);
					state_n = cmm_pkg::SR_PROBE;
				end
			end
			cmm_pkg::SR_PROBE: begin
				if (rd_data < req.code) begin
					lo_n = cmm_pkg::CNT_W'(mid_q) + cmm_pkg::CNT_W'(1);
				end else begin
					hi_n = cmm_pkg::CNT_W'(mid_q);
					eq_n = (rd_data == req.code);
				end
				if (lo_n < hi_n) begin
					mid_n = cmm_pkg::IDX_W'(lo_n + ((hi_n - lo_n) >> 1));
				end else begin
					cat_end = 1'b1;
					hit     = (lo_n < cat_count) && eq_n;
				end
			end
			default: begin
				state_n = cmm_pkg::SR_IDLE;
			end
		endcase
		if (cat_end) begin
			mask_n = mask_q | (cmm_pkg::MASK_W'(hit) << cat_q);
			if (cat_last) begin
				done_n  = 1'b1;
				state_n = cmm_pkg::SR_IDLE;
			end else begin
				cat_n   = cat_q + cmm_pkg::CAT_W'(1);
				state_n = cmm_pkg::SR_CAT;
			end
		end
	end

	assign rd_addr  = cmm_pkg::tbl_addr(cat_q, mid_n);
	assign cat      = cat_q;
	assign rsp.done = done_q;
	assign rsp.mask = mask_q;

endmodule

@@ design/category_code_match_mask_unit.sv @@
// Channel   Handshake               Payload
// input     in_valid / in_stall     mode, category, slot, entry_count, code, last_code
// output    out_valid / out_stall   visit_index, category_mask
//
// Table writes, count writes and unused modes never stall the input.
// A classify item runs a binary search in each of the 32 categories, one at a time through
// the single port of the code table memory; an item that ends a visit also passes ST_EMIT.
// in_stall stays high from the classify transfer until the search ends and any result
// has entered the output register; a result waits there under out_stall.
// Reset clears counts, mask, visit number and control; no clearing pass is needed.
module category_code_match_mask_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [cmm_pkg::MODE_W-1:0]   mode,
	input  logic [cmm_pkg::CATF_W-1:0]   category,
	input  logic [cmm_pkg::SLOT_W-1:0]   slot,
	input  logic [cmm_pkg::CNTF_W-1:0]   entry_count,
	input  logic [cmm_pkg::CODE_W-1:0]   code,
	input  logic                         last_code,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [cmm_pkg::VISIT_W-1:0]  visit_index,
	output logic [cmm_pkg::MASK_W-1:0]   category_mask
);

	cmm_pkg::ctl_state_t state_q, state_n;
	cmm_pkg::srch_req_t  req;
	cmm_pkg::srch_rsp_t  rsp;

	logic [cmm_pkg::CNT_W-1:0]   counts_q [cmm_pkg::NUM_CATEGORIES];
	logic [cmm_pkg::MASK_W-1:0]  acc_q;
	logic [cmm_pkg::VISIT_W-1:0] visit_q;
	logic                        out_valid_q;
	logic [cmm_pkg::VISIT_W-1:0] visit_index_q;
	logic [cmm_pkg::MASK_W-1:0]  category_mask_q;
	logic [cmm_pkg::CODE_W-1:0]  code_q;
	logic                        last_q;

	logic                        xfer, cat_ok, slot_ok, start, emit_load;
	logic                        ram_we;
	logic [cmm_pkg::CAT_W-1:0]   cat_idx, srch_cat;
	logic [cmm_pkg::CNT_W-1:0]   cnt_sat;
	logic [cmm_pkg::ADDR_W-1:0]  ram_addr, srch_addr;
	logic [cmm_pkg::CODE_W-1:0]  ram_rdata;

	assign xfer    = in_valid && !in_stall;
	assign cat_ok  = 32'(category) < 32'(cmm_pkg::NUM_CATEGORIES);
	assign slot_ok = 32'(slot) < 32'(cmm_pkg::ENTRIES_PER_CATEGORY);
	assign cat_idx = cmm_pkg::CAT_W'(category);
	assign cnt_sat = (32'(entry_count) > 32'(cmm_pkg::ENTRIES_PER_CATEGORY)) ?
		cmm_pkg::CNT_W'(cmm_pkg::ENTRIES_PER_CATEGORY) : cmm_pkg::CNT_W'(entry_count);

	assign ram_we   = xfer && (mode == cmm_pkg::MODE_WRITE) && cat_ok && slot_ok;
	assign ram_addr = ram_we ? cmm_pkg::tbl_addr(cat_idx, cmm_pkg::IDX_W'(slot)) : srch_addr;

	assign req.start = start;
	assign req.code  = code_q;

	cmm_ram #(
		.WIDTH(cmm_pkg::CODE_W),
		.DEPTH(cmm_pkg::TBL_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(code),
		.rdata(ram_rdata)
	);

	cmm_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cat      (srch_cat),
		.cat_count(counts_q[srch_cat]),
		.rd_addr  (srch_addr),
		.rd_data  (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cmm_pkg::ST_IDLE;
			acc_q       <= '0;
			visit_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < cmm_pkg::NUM_CATEGORIES; i++) begin
				counts_q[i] <= '0;
			end
		end else begin
			state_q <= state_n;
			if (xfer && (mode == cmm_pkg::MODE_COUNT) && cat_ok) begin
				counts_q[cat_idx] <= cnt_sat;
			end
			if ((state_q == cmm_pkg::ST_BUSY) && rsp.done) begin
				acc_q <= acc_q | rsp.mask;
			end else if (emit_load) begin
				acc_q <= '0;
			end
			if (emit_load) begin
				visit_q     <= visit_q + cmm_pkg::VISIT_W'(1);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			code_q <= code;
			last_q <= last_code;
		end
		if (emit_load) begin
			visit_index_q   <= visit_q;
			category_mask_q <= acc_q;
		end
	end

	always_comb begin
		state_n   = state_q;
		start     = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			cmm_pkg::ST_IDLE: begin
				if (xfer && (mode == cmm_pkg::MODE_CLASSIFY)) begin
					start   = 1'b1;
					state_n = cmm_pkg::ST_BUSY;
				end
			end
			cmm_pkg::ST_BUSY: begin
				if (rsp.done) begin
					state_n = last_q ? cmm_pkg::ST_EMIT : cmm_pkg::ST_IDLE;
				end
			end
			cmm_pkg::ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit_load = 1'b1;
					state_n   = cmm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = cmm_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall      = (state_q != cmm_pkg::ST_IDLE);
	assign out_valid     = out_valid_q;
	assign visit_index   = visit_index_q;
	assign category_mask = category_mask_q;

endmodule

@@ design/cmm_checker.sv @@
module cmm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [cmm_pkg::MODE_W-1:0]   mode,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [cmm_pkg::VISIT_W-1:0]  visit_index,
	input logic [cmm_pkg::MASK_W-1:0]   category_mask
);

	logic in_xfer;

	assign in_xfer = in_valid && !in_stall;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(visit_index) && $stable(category_mask))
		else $error("result changed while stalled");

	a_classify_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (mode == cmm_pkg::MODE_CLASSIFY) |=> in_stall)
		else $error("classify transfer did not start a search");

	a_load_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (mode != cmm_pkg::MODE_CLASSIFY) |=> !in_stall)
		else $error("load or unused mode stalled the input");

	a_result_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a search");

endmodule

bind category_code_match_mask_unit cmm_checker u_cmm_checker (.*);

@@ bench/visit_mask_monitor.sv @@
`timescale 1ns / 100ps
module visit_mask_monitor
	import cmm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [MODE_W-1:0]  mode,
	input  logic [CATF_W-1:0]  category,
	input  logic [SLOT_W-1:0]  slot,
	input  logic [CNTF_W-1:0]  entry_count,
	input  logic [CODE_W-1:0]  code,
	input  logic               last_code,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [VISIT_W-1:0] visit_index,
	input  logic [MASK_W-1:0]  category_mask,
	output int                 mismatches,
	output int                 awaited,
	output int                 checked
);

	typedef struct packed {
		logic [VISIT_W-1:0] visit;
		logic [MASK_W-1:0]  mask;
	} visit_result_t;

	logic [CODE_W-1:0] code_rows [NUM_CATEGORIES][ENTRIES_PER_CATEGORY];
	int unsigned       row_counts [NUM_CATEGORIES];
	logic [MASK_W-1:0] visit_mask = '0;
	logic [VISIT_W-1:0] visit_num = '0;
	visit_result_t     expected_visits [$];
	visit_result_t     head_visit;
	visit_result_t     closed_visit;
	int                fail_cnt = 0;
	int                queue_depth = 0;
	int                match_cnt = 0;

	assign mismatches = fail_cnt;
	assign awaited    = queue_depth;
	assign checked    = match_cnt;

	initial begin
		foreach (row_counts[i]) row_counts[i] = 0;
	end

	function automatic bit row_holds(int unsigned cat, logic [CODE_W-1:0] key);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		hi = row_counts[cat];
		while (lo < hi) begin
			mid = lo + ((hi - lo) >> 1);
			if (code_rows[cat][mid] < key)
				lo = mid + 1;
			else
				hi = mid;
		end
		if (lo >= row_counts[cat])
			return 1'b0;
		return code_rows[cat][lo] == key;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (row_counts[i]) row_counts[i] = 0;
			visit_mask = '0;
			visit_num  = '0;
			expected_visits.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_visits.size() == 0) begin
					$error("result transfer with no visit awaited: visit_index %0d, category_mask %h",
						visit_index, category_mask);
					fail_cnt++;
				end else begin
					head_visit = expected_visits.pop_front();
					match_cnt++;
					if (visit_index !== head_visit.visit) begin
						$error("visit_index: expected %0d, got %0d", head_visit.visit, visit_index);
						fail_cnt++;
					end
					if (category_mask !== head_visit.mask) begin
						$error("category_mask: expected %h, got %h", head_visit.mask, category_mask);
						fail_cnt++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (mode)
					MODE_WRITE: begin
						if (int'(category) < NUM_CATEGORIES && int'(slot) < ENTRIES_PER_CATEGORY)
							code_rows[category][slot] = code;
					end
					MODE_COUNT: begin
						if (int'(category) < NUM_CATEGORIES)
							row_counts[category] = (int'(entry_count) > ENTRIES_PER_CATEGORY) ?
								ENTRIES_PER_CATEGORY : int'(entry_count);
					end
					MODE_CLASSIFY: begin
						for (int c = 0; c < SEARCHED; c++)
							if (row_holds(c, code))
								visit_mask[c] = 1'b1;
						if (last_code) begin
							closed_visit.visit = visit_num;
							closed_visit.mask  = visit_mask;
							expected_visits.insert(expected_visits.size(), closed_visit);
							visit_mask = '0;
							visit_num  = visit_num + VISIT_W'(1);
						end
					end
					default: ;
				endcase
			end
		end
		queue_depth = expected_visits.size();
	end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
	import cmm_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT     = 4_000_000;
	localparam int HOLD_CYCLES     = 1500;
	localparam int DRAIN_CYCLES    = 400;
	localparam int CODE_MAX        = 99999;
	localparam int ITEMS_PER_PHASE = 385;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic [MODE_W-1:0]  mode        = '0;
	logic [CATF_W-1:0]  category    = '0;
	logic [SLOT_W-1:0]  slot        = '0;
	logic [CNTF_W-1:0]  entry_count = '0;
	logic [CODE_W-1:0]  code        = '0;
	logic               last_code   = 1'b0;
	logic               out_stall   = 1'b0;
	logic               in_stall;
	logic               out_valid;
	logic [VISIT_W-1:0] visit_index;
	logic [MASK_W-1:0]  category_mask;
	int                 mismatches;
	int                 awaited;
	int                 checked;

	int snd_pct   = 0;
	int rcv_pct   = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycles    = 0;

	int items_sent   = 0;
	int ignored_sent = 0;
	int writes_sent  = 0;
	int codes_sent   = 0;
	int visits_sent  = 0;

	bit          written [NUM_CATEGORIES][ENTRIES_PER_CATEGORY];
	int unsigned loaded [NUM_CATEGORIES][ENTRIES_PER_CATEGORY];
	int unsigned live_count [NUM_CATEGORIES];

	always #5 clk = ~clk;

	category_code_match_mask_unit u_top (.*);

	visit_mask_monitor u_mon (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_pct);
		end
	end

	task automatic send_item(input logic [MODE_W-1:0] m, input int unsigned cat,
		input int unsigned sl, input int unsigned cnt, input int unsigned cd, input bit lst);
		in_valid    <= 1'b1;
		mode        <= m;
		category    <= CATF_W'(cat);
		slot        <= SLOT_W'(sl);
		entry_count <= CNTF_W'(cnt);
		code        <= CODE_W'(cd);
		last_code   <= lst;
		do @(posedge clk); while (in_stall);
		items_sent++;
		while ($urandom_range(99) < snd_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_entry(input int unsigned cat, input int unsigned sl, input int unsigned cd);
		send_item(MODE_WRITE, cat, sl, $urandom_range(511), cd, 1'($urandom_range(1)));
		written[cat][sl] = 1'b1;
		loaded[cat][sl]  = cd;
		writes_sent++;
	endtask

	task automatic set_count(input int unsigned cat, input int unsigned cnt);
		send_item(MODE_COUNT, cat, $urandom_range(255), cnt, $urandom_range(CODE_MAX),
			1'($urandom_range(1)));
		live_count[cat] = (cnt > ENTRIES_PER_CATEGORY) ? ENTRIES_PER_CATEGORY : cnt;
	endtask

	task automatic classify(input int unsigned cd, input bit lst);
		send_item(MODE_CLASSIFY, $urandom_range(31), $urandom_range(255), $urandom_range(511),
			cd, lst);
		codes_sent++;
		if (lst)
			visits_sent++;
	endtask

	task automatic send_unused();
		send_item(MODE_UNUSED, $urandom_range(31), $urandom_range(255), $urandom_range(511),
			$urandom_range(CODE_MAX), 1'($urandom_range(1)));
		ignored_sent++;
	endtask

	function automatic int unsigned written_prefix(input int unsigned cat);
		int unsigned n;
		n = 0;
		while (n < ENTRIES_PER_CATEGORY && written[cat][n])
			n++;
		return n;
	endfunction

	// sorted ascending with repeats allowed, then set the category's live count to cnt
	task automatic load_sorted(input int unsigned cat, input int unsigned n, input int unsigned cnt);
		int unsigned step;
		int unsigned val;
		step = CODE_MAX / (n + 1);
		val  = $urandom_range(step);
		for (int unsigned i = 0; i < n; i++) begin
			write_entry(cat, i, val);
			val += $urandom_range(step);
		end
		set_count(cat, cnt);
	endtask

	function automatic int unsigned pick_code();
		int unsigned r;
		int unsigned cat;
		int unsigned val;
		r   = $urandom_range(99);
		cat = $urandom_range(NUM_CATEGORIES - 1);
		if (r < 60 && live_count[cat] > 0) begin
			val = loaded[cat][$urandom_range(live_count[cat] - 1)];
			if (r >= 45) begin
				if ($urandom_range(1))
					val = (val < CODE_MAX) ? val + 1 : val;
				else
					val = (val > 0) ? val - 1 : val;
			end
			return val;
		end
		if (r < 65)
			return $urandom_range(1) ? CODE_MAX : 0;
		return $urandom_range(CODE_MAX);
	endfunction

	task automatic run_visit();
		int unsigned n;
		n = $urandom_range(1, 4);
		for (int unsigned i = 0; i < n; i++)
			classify(pick_code(), i == n - 1);
	endtask

	task automatic random_step();
		int unsigned r;
		int unsigned cat;
		int unsigned pre;
		r   = $urandom_range(99);
		cat = $urandom_range(NUM_CATEGORIES - 1);
		pre = written_prefix(cat);
		if (r < 50) begin
			run_visit();
		end else if (r < 70) begin
			if ($urandom_range(3) == 0)
				load_sorted(cat, $urandom_range(13, 48), 0);
			else
				load_sorted(cat, $urandom_range(12), 0);
			set_count(cat, written_prefix(cat) < 13 ? written_prefix(cat) :
				$urandom_range(written_prefix(cat)));
		end else if (r < 78) begin
			if (pre == ENTRIES_PER_CATEGORY && $urandom_range(1))
				set_count(cat, $urandom_range(ENTRIES_PER_CATEGORY, 511));
			else
				set_count(cat, $urandom_range(pre));
		end else if (r < 86) begin
			// stray write: may break ordering or leave a hole past the live run
			if ($urandom_range(1))
				write_entry(cat, (pre < ENTRIES_PER_CATEGORY) ? $urandom_range(pre) : 255,
					$urandom_range(CODE_MAX));
			else
				write_entry(cat, $urandom_range(255), $urandom_range(CODE_MAX));
		end else if (r < 92) begin
			send_unused();
		end else begin
			classify($urandom_range(CODE_MAX), 1'b0);
		end
	endtask

	initial begin
		int phase_start;
		int unsigned big_cat;
		foreach (live_count[i]) live_count[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty tables, unused mode, field extremes, misses, zero count, repeats
		classify(0, 1'b1);
		send_item(MODE_UNUSED, 31, 255, 511, CODE_MAX, 1'b1);
		ignored_sent++;
		write_entry(0, 0, 0);
		write_entry(31, 0, CODE_MAX);
		write_entry(5, 0, 10);
		write_entry(5, 1, 65536);
		write_entry(5, 2, CODE_MAX);
		write_entry(9, 255, 12345);
		set_count(0, 1);
		set_count(31, 1);
		set_count(5, 3);
		classify(0, 1'b0);
		classify(CODE_MAX, 1'b1);
		classify(65536, 1'b1);
		classify(11, 1'b1);
		set_count(5, 0);
		classify(10, 1'b1);
		set_count(5, 3);
		write_entry(6, 0, 500);
		write_entry(6, 1, 500);
		set_count(6, 2);
		classify(500, 1'b0);
		classify(65535, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin snd_pct = 0;  rcv_pct <= 0;  end
				1: begin snd_pct = 73; rcv_pct <= 0;  end
				2: begin snd_pct = 0;  rcv_pct <= 73; end
				default: begin snd_pct = 9; rcv_pct <= 9; end
			endcase
			phase_start = items_sent - ignored_sent;
			if (ph == 0) begin
				big_cat = $urandom_range(1, NUM_CATEGORIES - 1);
				load_sorted(big_cat, ENTRIES_PER_CATEGORY, $urandom_range(257, 511));
				run_visit();
				set_count(big_cat, ENTRIES_PER_CATEGORY);
				run_visit();
			end
			while (items_sent - ignored_sent - phase_start < ITEMS_PER_PHASE)
				random_step();
			if (ph == 1) begin
				// hold the result side off while items keep coming, then drain
				snd_pct = 0;
				hold_reqs <= hold_reqs + 1;
				for (int i = 0; i < 6; i++)
					classify(pick_code(), 1'b1);
				drop_valid();
				while (awaited != 0)
					@(posedge clk);
			end
		end

		drop_valid();
		while (awaited != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited != 0) begin
			$error("%0d expected visit results never arrived", awaited);
		end
		$display("covered %0d transfers: %0d table writes, %0d classify codes over %0d visits, %0d ignored",
			items_sent, writes_sent, codes_sent, visits_sent, ignored_sent);
		$display("%0d visit results compared in %0d cycles", checked, cycles);
		if (mismatches == 0 && awaited == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
